@@ src/sha_pkg.sv @@
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_EMIT
  } back_state_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_vec(input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/sha_if.sv @@
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;
  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

@@ src/sha_front.sv @@
module sha_front
  import sha_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  sha_in_if.sink in_ch,
  output logic   q_valid,
  output cmd_t   q_data,
  input  logic   q_pop
);

  // two-entry queue; empty beats are dropped here
  cmd_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       useful;

  assign in_ch.ready = (count != 2'd2);
  assign useful = in_ch.byte_present | in_ch.end_of_message;
  assign push = in_ch.valid & in_ch.ready & useful;
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= '{in_ch.msg_byte, in_ch.byte_present, in_ch.end_of_message};
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

@@ src/sha_back.sv @@
module sha_back
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_pop,
  sha_out_if.source  out_ch
);

  back_state_t state, state_next;
  word_t       h [8];
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [63:0] total;
  logic [5:0]  rnd;
  logic [2:0]  emit_idx;
  logic        finish_pending;
  logic        finishing;
  logic        last_block;

  // byte shifting into the 16-word schedule window
  logic        take_byte;
  logic        pad_byte;
  logic [7:0]  shift_byte;
  logic        block_full;

  word_t s0, s1, w_new, t1, t2, ch, maj;

  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_new = s1 + w[9] + s0 + w[0];
  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
              + round_k(rnd) + w[0];
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;

  assign take_byte = (state == ST_TAKE) && q_valid && q_data.byte_present;
  assign block_full = (fill == 6'd63);

  always_comb begin
    state_next = state;
    case (state)
      ST_TAKE: begin
        if (q_valid) begin
          if (q_data.byte_present && block_full) state_next = ST_COMP;
          else if (q_data.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill == 6'd55) state_next = ST_LEN;
        else if (fill == 6'd63) state_next = ST_COMP;
      end
      ST_LEN:  if (fill == 6'd63) state_next = ST_COMP;
      ST_COMP: begin
        if (rnd == 6'(Rounds - 1)) begin
          if (last_block) state_next = ST_EMIT;
          else if (finishing) state_next = ST_PAD;
          else state_next = ST_TAKE;
        end
      end
      ST_EMIT: if (out_ch.ready && emit_idx == 3'd7) state_next = ST_TAKE;
      default: state_next = ST_TAKE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    pad_byte = 1'b0;
    shift_byte = q_data.msg_byte;
    case (state)
      ST_TAKE: q_pop = q_valid;
      ST_PAD: begin
        pad_byte = 1'b1;
        shift_byte = finish_pending ? 8'h80 : 8'h00;
      end
      ST_LEN: begin
        pad_byte = 1'b1;
        shift_byte = total[6'(8 * (63 - fill)) +: 8];
      end
      default: ;
    endcase
  end

  assign out_ch.valid = (state == ST_EMIT);
  assign out_ch.digest_word = h[emit_idx];
  assign out_ch.word_number = emit_idx;
  assign out_ch.final_word = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
      fill <= '0;
      bit_count <= '0;
      rnd <= '0;
      emit_idx <= '0;
      finish_pending <= 1'b0;
      finishing <= 1'b0;
      last_block <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= init_vec(3'(i));
    end else begin
      state <= state_next;
      case (state)
        ST_TAKE: begin
          if (take_byte) begin
            fill <= fill + 6'd1;
            if (block_full) bit_count <= bit_count + 64'd512;
          end
          if (q_valid && q_data.end_of_message) begin
            finish_pending <= 1'b1;
            finishing <= 1'b1;
            // capture the length before padding starts
            total <= bit_count + {55'd0, fill + 6'(take_byte), 3'd0}
                     + (take_byte && block_full ? 64'd512 : 64'd0);
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          finish_pending <= 1'b0;
        end
        ST_LEN: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) last_block <= 1'b1;
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(Rounds - 1)) begin
            // fold in the last round as it is computed
            h[0] <= h[0] + t1 + t2;
            h[1] <= h[1] + v[0];
            h[2] <= h[2] + v[1];
            h[3] <= h[3] + v[2];
            h[4] <= h[4] + v[3] + t1;
            h[5] <= h[5] + v[4];
            h[6] <= h[6] + v[5];
            h[7] <= h[7] + v[6];
          end
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              last_block <= 1'b0;
              finishing <= 1'b0;
              bit_count <= '0;
              fill <= '0;
              for (int i = 0; i < 8; i++) h[i] <= init_vec(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: schedule window and working variables
  always_ff @(posedge clk) begin
    if (take_byte || pad_byte) begin
      w[fill[5:2]] <= {w[fill[5:2]][23:0], shift_byte};
      if (fill == 6'd63 || (state == ST_TAKE && block_full)) begin
        for (int i = 0; i < 8; i++) v[i] <= h[i];
      end
    end
    if (state == ST_COMP) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end

  a_emit_only_after_comp: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EMIT) |-> $past(state) == ST_COMP) else $error("emit without compress");
  a_comp_starts_full: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_COMP) |-> fill == 6'd0 && rnd == 6'd0) else $error("partial block");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_TAKE |-> !q_pop) else $error("pop while busy");

endmodule

@@ src/sha256_message_hasher_top.sv @@
// SHA-256 hasher. Bytes enter one per beat; each 64th byte triggers a
// compression, one round per cycle, during which no bytes are taken.
// An end-of-message beat adds padding and length at one byte a cycle
// (up to two blocks), then eight digest beats H0..H7 follow; the state
// then returns to the initial vector. A two-beat queue in front lets the
// input take two more beats while a block compresses.
module sha256_message_hasher_top
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  logic q_valid;
  logic q_pop;
  cmd_t q_data;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  sha_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_ch(out_ch)
  );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import sha_pkg::*;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_message_hasher_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #10 clk = ~clk;

  // Predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] done_bits;

  digest_beat_t digest_q [$];
  int unsigned  n_errors;
  int unsigned  n_items;
  int unsigned  n_digests;
  int unsigned  idle_cnt;
  bit           allow_gaps;
  bit           hold_sink;
  int unsigned  hold_cycles;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + K_TAB[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_msg();
    for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
    blk_fill  = 0;
    done_bits = '0;
  endtask

  // Absorb one accepted beat and queue the digest it produces, if any.
  task automatic predict_digest(cmd_t c);
    int unsigned pos;
    logic [63:0] total;
    digest_beat_t d;
    if (c.byte_present) begin
      blk_bytes[blk_fill] = c.msg_byte;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_blk();
        done_bits += 64'd512;
        blk_fill = 0;
      end
    end
    if (!c.end_of_message) return;
    pos = blk_fill;
    total = done_bits + 64'(pos * 8);
    blk_bytes[pos++] = 8'h80;
    if (pos > 56) begin
      while (pos < 64) blk_bytes[pos++] = 8'h00;
      compress_blk();
      pos = 0;
    end
    while (pos < 56) blk_bytes[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[63-i] = total[8*i +: 8];
    compress_blk();
    for (int j = 0; j < 8; j++) begin
      d.digest_word = hash_state[j];
      d.word_number = 3'(j);
      d.final_word  = (j == 7);
      digest_q.push_back(d);
    end
    restart_msg();
  endtask

  task automatic send_cmd(logic [7:0] b, logic pres, logic eom);
    int unsigned gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.msg_byte       <= b;
    in_ch.byte_present   <= pres;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_digest('{msg_byte: b, byte_present: pres, end_of_message: eom});
    n_items++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++) send_cmd(8'($urandom), 1'b1, 1'b0);
    send_cmd(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_cmd(8'h00, 1'b0, 1'b1);              // empty message
    send_cmd(8'h61, 1'b1, 1'b0);               // "abc"
    send_cmd(8'h62, 1'b1, 1'b0);
    send_cmd(8'h63, 1'b1, 1'b1);               // byte and end marker together
    send_cmd(8'hff, 1'b0, 1'b0);               // nothing at all
    send_cmd(8'hff, 1'b1, 1'b0);
    send_cmd(8'h00, 1'b1, 1'b0);
    send_cmd(8'haa, 1'b0, 1'b0);
    send_cmd(8'h55, 1'b1, 1'b1);
    send_cmd(8'h00, 1'b0, 1'b1);               // empty message right after the previous one ends
  endtask

  // Lengths that straddle the padding limit and block boundaries.
  task automatic test_pad_edges();
    int unsigned lens [2] = '{55, 56};
    foreach (lens[i]) send_message(lens[i]);
    for (int i = 0; i < 64; i++) send_cmd(8'($urandom), 1'b1, i == 63);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    hold_sink   = 1'b1;
    send_message(20);
    send_message(3);
    send_message(0);
  endtask

  task automatic test_random();
    int unsigned len;
    for (int m = 0; n_items < 280; m++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) begin
        // scatter empty beats through the message as noise
        if ($urandom_range(0, 7) == 0) send_cmd(8'($urandom), 1'b0, 1'b0);
        send_cmd(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
        if (in_ch.end_of_message) break;
      end
      if (!in_ch.end_of_message || !in_ch.valid) send_cmd(8'($urandom), 1'b0, 1'b1);
      if (n_items > 240) allow_gaps = 1'b0;
    end
  endtask

  // Result checker and sink stalls
  initial begin
    int unsigned stall;
    bit held;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_sink && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
      end
      if (allow_gaps && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_digests++;
      if (digest_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected digest beat %h word %0d", $time,
                 out_ch.digest_word, out_ch.word_number);
      end else begin
        digest_beat_t exp_b;
        exp_b = digest_q.pop_front();
        if (out_ch.digest_word !== exp_b.digest_word) begin
          n_errors++;
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_b.digest_word, out_ch.digest_word);
        end
        if (out_ch.word_number !== exp_b.word_number) begin
          n_errors++;
          $display("%0t: word_number expected %0d actual %0d", $time,
                   exp_b.word_number, out_ch.word_number);
        end
        if (out_ch.final_word !== exp_b.final_word) begin
          n_errors++;
          $display("%0t: final_word expected %b actual %b", $time,
                   exp_b.final_word, out_ch.final_word);
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.msg_byte       = '0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    n_errors = 0; n_items = 0; n_digests = 0;
    hold_sink = 1'b0; hold_cycles = 0; allow_gaps = 1'b1;
    restart_msg();
    for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_pad_edges();
    test_backpressure();
    test_random();
    idle_input();
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d input beats and checked %0d digest words, including padding",
             n_items, n_digests);
    $display("edges, empty messages, multi-block messages and a long output stall.");
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/sha_pkg.sv
src/sha_if.sv
src/sha_front.sv
src/sha_back.sv
src/sha256_message_hasher_top.sv
dv/tb_top.sv
